// File: rtl/core/rgb2hsv_pkg.sv
// ============================================================================
// rgb2hsv_pkg
// Types and constants shared by the RGB to HSV pixel converter.
// ============================================================================
package rgb2hsv_pkg;

    localparam int ChanW = 8;
    localparam int HueW  = 9;
    localparam int QBits = 8;   // quotient bits, one per divide stage
    localparam int NumW  = 16;  // holds 255 * 255

    localparam logic [HueW-1:0]  HueBaseRed    = 9'd0;
    localparam logic [HueW-1:0]  HueBaseRedNeg = 9'd360;
    localparam logic [HueW-1:0]  HueBaseGreen  = 9'd120;
    localparam logic [HueW-1:0]  HueBaseBlue   = 9'd240;
    localparam logic [NumW-1:0]  HueScale      = 16'd60;
    localparam logic [NumW-1:0]  SatScale      = 16'd255;
    localparam logic [ChanW-1:0] SatFull       = 8'd255;

    typedef enum logic [1:0] {
        SEC_GREY,
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    typedef struct packed {
        logic [ChanW-1:0] cmax;
        logic [ChanW-1:0] cmin;
        logic [ChanW-1:0] delta;
        logic [ChanW-1:0] dabs;
        logic             neg;
        sector_t          sector;
    } front_t;

    typedef struct packed {
        logic [NumW-1:0]  rem_h;
        logic [NumW-1:0]  rem_s;
        logic [ChanW-1:0] div_h;
        logic [ChanW-1:0] div_s;
        logic [QBits-1:0] q_h;
        logic [QBits-1:0] q_s;
        logic             neg;
        sector_t          sector;
    } pipe_t;

endpackage

// File: rtl/core/rgb_to_hsv_pixel_convert.sv
// ============================================================================
// rgb_to_hsv_pixel_convert
// Pipelined 8-bit RGB to integer HSV converter with two restoring dividers.
// ============================================================================
//  channel  | ports                                  | dir
//  ---------+----------------------------------------+-----
//  pixel    | s_valid s_ready s_blue s_green s_red   | in
//  hsv      | m_valid m_ready m_hue m_saturation     | out
//           | m_brightness                           |
//
//  One pixel per clock sustained while m_ready is held high.
//  Stages: min/max and sector, constant scaling, eight restoring divide
//  steps (one quotient bit each for hue and saturation), final offset.
//  Each stage has its own valid bit and accepts whenever it is empty or the
//  next stage moves, so stalls close bubbles and lose nothing.
//  aresetn clears all valid bits; payload registers are not reset.
// ============================================================================
module rgb_to_hsv_pixel_convert (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_blue,
    input  logic [7:0] s_green,
    input  logic [7:0] s_red,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [8:0] m_hue,
    output logic [7:0] m_saturation,
    output logic [7:0] m_brightness
);
    import rgb2hsv_pkg::*;

    localparam int NStg = QBits + 3;
    localparam int OutStg = NStg - 1;

    logic [NStg-1:0] vld_reg;
    logic [NStg-1:0] vld_next;
    logic [NStg:0]   rdy;

    front_t front_reg;
    front_t front_next;
    pipe_t  div_reg  [QBits+1];
    pipe_t  div_next [QBits+1];

    logic [HueW-1:0]  hue_reg;
    logic [HueW-1:0]  hue_next;
    logic [ChanW-1:0] sat_reg;
    logic [ChanW-1:0] sat_next;
    logic [ChanW-1:0] bright_reg;
    logic [ChanW-1:0] cmax_pipe_reg [QBits+1];

    // per-stage handshake
    assign rdy[NStg] = m_ready;
    for (genvar i = 0; i < NStg; i++) begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
        if (i == 0) begin : g_first
            assign vld_next[i] = rdy[i] ? s_valid : vld_reg[i];
        end else begin : g_rest
            assign vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[0];

    // stage 0: max, min, sector, channel difference
    always_comb begin
        logic [ChanW-1:0] mx;
        logic [ChanW-1:0] mn;
        logic [ChanW-1:0] pa;
        logic [ChanW-1:0] pb;
        mx = s_blue;
        mn = s_blue;
        if (s_green > mx) mx = s_green;
        if (s_red > mx)   mx = s_red;
        if (s_green < mn) mn = s_green;
        if (s_red < mn)   mn = s_red;
        if (mx == mn) begin
            front_next.sector = SEC_GREY;
            pa = s_green;
            pb = s_blue;
        end else if (mx == s_red) begin
            front_next.sector = SEC_RED;
            pa = s_green;
            pb = s_blue;
        end else if (mx == s_green) begin
            front_next.sector = SEC_GREEN;
            pa = s_blue;
            pb = s_red;
        end else begin
            front_next.sector = SEC_BLUE;
            pa = s_red;
            pb = s_green;
        end
        front_next.cmax  = mx;
        front_next.cmin  = mn;
        front_next.delta = mx - mn;
        front_next.neg   = pa < pb;
        front_next.dabs  = (pa < pb) ? (pb - pa) : (pa - pb);
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && s_valid) begin
            front_reg <= front_next;
        end
    end

    // stage 1: scale numerators
    always_comb begin
        div_next[0].rem_h  = NumW'(front_reg.dabs) * HueScale;
        div_next[0].rem_s  = NumW'(front_reg.cmin) * SatScale;
        div_next[0].div_h  = front_reg.delta;
        div_next[0].div_s  = front_reg.cmax;
        div_next[0].q_h    = '0;
        div_next[0].q_s    = '0;
        div_next[0].neg    = front_reg.neg;
        div_next[0].sector = front_reg.sector;
    end

    // stages 2..QBits+1: one restoring divide step each, MSB first
    for (genvar k = 1; k <= QBits; k++) begin : g_div
        localparam int Bit = QBits - k;
        always_comb begin
            logic [NumW-1:0] th;
            logic [NumW-1:0] ts;
            th = NumW'(div_reg[k-1].div_h) << Bit;
            ts = NumW'(div_reg[k-1].div_s) << Bit;
            div_next[k] = div_reg[k-1];
            if (div_reg[k-1].rem_h >= th) begin
                div_next[k].rem_h    = div_reg[k-1].rem_h - th;
                div_next[k].q_h[Bit] = 1'b1;
            end
            if (div_reg[k-1].rem_s >= ts) begin
                div_next[k].rem_s    = div_reg[k-1].rem_s - ts;
                div_next[k].q_s[Bit] = 1'b1;
            end
        end
    end

    for (genvar j = 0; j <= QBits; j++) begin : g_div_reg
        always_ff @(posedge aclk) begin
            if (rdy[j+1] && vld_reg[j]) begin
                div_reg[j] <= div_next[j];
                if (j == 0) begin
                    cmax_pipe_reg[j] <= front_reg.cmax;
                end else begin
                    cmax_pipe_reg[j] <= cmax_pipe_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    // last stage: hue offset and saturation complement
    always_comb begin
        logic [HueW-1:0] base;
        logic [HueW-1:0] q;
        q = HueW'(div_reg[QBits].q_h);
        case (div_reg[QBits].sector)
            SEC_RED:   base = div_reg[QBits].neg ? HueBaseRedNeg : HueBaseRed;
            SEC_GREEN: base = HueBaseGreen;
            SEC_BLUE:  base = HueBaseBlue;
            default:   base = '0;
        endcase
        if (div_reg[QBits].sector == SEC_GREY) begin
            hue_next = '0;
        end else if (div_reg[QBits].neg) begin
            hue_next = base - q;
        end else begin
            hue_next = base + q;
        end
        if (cmax_pipe_reg[QBits] == '0) begin
            sat_next = '0;
        end else begin
            sat_next = SatFull - div_reg[QBits].q_s;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[OutStg] && vld_reg[OutStg-1]) begin
            hue_reg    <= hue_next;
            sat_reg    <= sat_next;
            bright_reg <= cmax_pipe_reg[QBits];
        end
    end

    assign m_valid      = vld_reg[OutStg];
    assign m_hue        = hue_reg;
    assign m_saturation = sat_reg;
    assign m_brightness = bright_reg;

endmodule

// File: rtl/core/rgb2hsv_checker.sv
// ============================================================================
// rgb2hsv_checker
// Port-level checks on the converter's result channel.
// ============================================================================
module rgb2hsv_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [8:0] m_hue,
    input logic [7:0] m_saturation,
    input logic [7:0] m_brightness
);

    // no result straight out of reset
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hue)
            && $stable(m_saturation) && $stable(m_brightness))
        else $error("stalled result changed");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hue <= 9'd360)
        else $error("hue above 360");

    // zero saturation only for grey pixels, which have zero hue
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation == 8'd0 |-> m_hue == 9'd0)
        else $error("grey pixel with nonzero hue");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_brightness == 8'd0 |-> m_saturation == 8'd0)
        else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_pixel_convert rgb2hsv_checker u_rgb2hsv_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hue        (m_hue),
    .m_saturation (m_saturation),
    .m_brightness (m_brightness)
);
